### sv/kvct_pkg.sv
`timescale 1ns / 1ps

package kvct_pkg;

    // scanner states
    typedef enum logic [2:0] {
        ST_DIVIDER = 3'd0,
        ST_COMMENT = 3'd1,
        ST_NAME    = 3'd2,
        ST_VALUE   = 3'd3,
        ST_ESCAPE  = 3'd4,
        ST_QUOTE_D = 3'd5,
        ST_QUOTE_S = 3'd6
    } t_scan_state;

    // result kinds
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_NAME  = 3'd1,
        K_VALUE = 3'd2,
        K_PAIR  = 3'd3,
        K_ERROR = 3'd4,
        K_END   = 3'd5
    } t_kind;

    localparam logic [7:0] CH_COMMENT = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_QUOTE_D = 8'h22;
    localparam logic [7:0] CH_QUOTE_S = 8'h27;
    localparam logic [7:0] CH_ESCAPE  = 8'h5C;

    // one result word
    typedef struct packed {
        t_kind      kind;
        logic [7:0] token_char;
        logic       partial_dropped;
        logic       halted;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

### sv/key_value_config_tokenizer.sv
`timescale 1ns / 1ps

// name=value line tokenizer, one text byte per word
// slave channel: tdata carries the byte, tlast marks end of text (byte ignored)
// master channel: one result word per input word; tuser carries the token
// kind (none, name char, value char, pair complete, syntax error, end), tdata
// carries the character, the partial-pair flag at end and the halted flag
// an accepted word passes through the input register, then the scanner logic
// into the result register
// throughput: one word per cycle unless the receiver stalls; the scanner state
// is a small register, updated as each word moves from input to result register
// reset: scanner returns to the divider state, halt flag clears, both
// registers empty
// when the receiver stalls the result register holds, the input register
// fills, and then tready drops until the result word is taken
// after a syntax error every word yields kind none with halted set until reset
module key_value_config_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_input
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] token_char, [8] partial_dropped,
                                          // [9] halted, [15:10] zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] token_kind
);
    import kvct_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_eoi;
    logic              r_out_valid;
    t_result           r_out;
    t_scan_state       r_state;
    logic              r_halt;
    t_scan_state       n_state;
    logic              n_halt;
    t_result           n_out;
    logic              w_advance;

    // input word moves into the result register when that is free or draining
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    kvct_step u_step (
        .i_state  (r_state),
        .i_halt   (r_halt),
        .i_byte   (r_in_byte),
        .i_eoi    (r_in_eoi),
        .o_state  (n_state),
        .o_halt   (n_halt),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eoi  <= i_s_axis_tlast;
        end
    end

    // scanner state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DIVIDER;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_state     <= n_state;
                r_halt      <= n_halt;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {6'd0, r_out.halted, r_out.partial_dropped, r_out.token_char};

endmodule

### sv/kvct_step.sv
`timescale 1ns / 1ps

// next-state and result logic of the scanner for one byte
module kvct_step (
    input  kvct_pkg::t_scan_state i_state,
    input  logic                  i_halt,
    input  logic [7:0]            i_byte,
    input  logic                  i_eoi,
    output kvct_pkg::t_scan_state o_state,
    output logic                  o_halt,
    output kvct_pkg::t_result     o_result
);
    import kvct_pkg::*;

    logic w_error;

    // next state
    always_comb begin
        o_state = i_state;
        w_error = 1'b0;
        if (i_halt) begin
            o_state = i_state;
        end else if (i_eoi) begin
            o_state = ST_DIVIDER;
        end else begin
            case (i_state)
                ST_COMMENT: begin
                    if (i_byte == CH_NEWLINE) o_state = ST_DIVIDER;
                end
                ST_NAME: begin
                    if (is_alnum(i_byte)) o_state = ST_NAME;
                    else if (i_byte == CH_EQUALS) o_state = ST_VALUE;
                    else w_error = 1'b1;
                end
                ST_VALUE: begin
                    if (i_byte == CH_QUOTE_D) o_state = ST_QUOTE_D;
                    else if (i_byte == CH_QUOTE_S) o_state = ST_QUOTE_S;
                    else if (i_byte == CH_ESCAPE) o_state = ST_ESCAPE;
                    else if (is_space(i_byte)) o_state = ST_DIVIDER;
                end
                ST_ESCAPE: begin
                    o_state = ST_VALUE;
                end
                ST_QUOTE_D: begin
                    if (i_byte == CH_QUOTE_D) o_state = ST_VALUE;
                end
                ST_QUOTE_S: begin
                    if (i_byte == CH_QUOTE_S) o_state = ST_VALUE;
                end
                default: begin
                    // divider, and the unused code
                    if (is_letter(i_byte)) o_state = ST_NAME;
                    else if (i_byte == CH_COMMENT) o_state = ST_COMMENT;
                    else if (!is_space(i_byte)) w_error = 1'b1;
                    else o_state = ST_DIVIDER;
                end
            endcase
        end
        o_halt = i_halt | w_error;
    end

    // result word
    always_comb begin
        o_result.kind            = K_NONE;
        o_result.token_char      = 8'd0;
        o_result.partial_dropped = 1'b0;
        o_result.halted          = o_halt;
        if (i_halt) begin
            o_result.kind = K_NONE;
        end else if (i_eoi) begin
            o_result.kind            = K_END;
            o_result.partial_dropped = (i_state == ST_NAME) || (i_state == ST_VALUE)
                                    || (i_state == ST_ESCAPE) || (i_state == ST_QUOTE_D)
                                    || (i_state == ST_QUOTE_S);
        end else if (w_error) begin
            o_result.kind = K_ERROR;
        end else begin
            case (i_state)
                ST_COMMENT: begin
                    o_result.kind = K_NONE;
                end
                ST_NAME: begin
                    o_result.kind       = K_NAME;
                    o_result.token_char = is_alnum(i_byte) ? i_byte : 8'd0;
                    if (!is_alnum(i_byte)) o_result.kind = K_NONE;
                end
                ST_VALUE: begin
                    if (is_space(i_byte)) begin
                        o_result.kind = K_PAIR;
                    end else if (i_byte != CH_QUOTE_D && i_byte != CH_QUOTE_S
                                 && i_byte != CH_ESCAPE) begin
                        o_result.kind       = K_VALUE;
                        o_result.token_char = i_byte;
                    end
                end
                ST_ESCAPE: begin
                    if (i_byte != CH_NEWLINE) begin
                        o_result.kind       = K_VALUE;
                        o_result.token_char = i_byte;
                    end
                end
                ST_QUOTE_D: begin
                    if (i_byte != CH_QUOTE_D) begin
                        o_result.kind       = K_VALUE;
                        o_result.token_char = i_byte;
                    end
                end
                ST_QUOTE_S: begin
                    if (i_byte != CH_QUOTE_S) begin
                        o_result.kind       = K_VALUE;
                        o_result.token_char = i_byte;
                    end
                end
                default: begin
                    if (is_letter(i_byte)) begin
                        o_result.kind       = K_NAME;
                        o_result.token_char = i_byte;
                    end
                end
            endcase
        end
    end

endmodule
